// ===== sv/midi_track_event_parser_unit_assert.svh =====
// Assertion macros shared by the track parser RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef MIDI_TRACK_EVENT_PARSER_UNIT_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define MTEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mtep_pkg.sv =====
// Types and constants for the MIDI track event parser.
// No dependencies; used by mtep_core and the top level.
`default_nettype none

package mtep_pkg;

  typedef enum logic [3:0] {
    PH_DELTA    = 4'd0,
    PH_STATUS   = 4'd1,
    PH_DATA1    = 4'd2,
    PH_DATA2    = 4'd3,
    PH_SYSLEN   = 4'd4,
    PH_SKIP     = 4'd5,
    PH_METATYPE = 4'd6,
    PH_METALEN  = 4'd7,
    PH_TEMPO    = 4'd8
  } mtep_phase_t;

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd2;
  localparam logic [2:0] KIND_TEMPO    = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN  = 3'd4;

  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
  localparam logic [7:0] ST_META       = 8'hFF;
  localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
  localparam logic [3:0] HI_NOTE_ON    = 4'h9;
  localparam logic [3:0] HI_PROG       = 4'hC;
  localparam logic [3:0] HI_PRESSURE   = 4'hD;
  localparam logic [3:0] HI_SYSTEM     = 4'hF;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] META_EOT      = 8'h2F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
  } mtep_in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] event_ticks;
    logic [3:0]  channel;
    logic [7:0]  note_number;
    logic [7:0]  velocity;
    logic [23:0] tempo_us;
    logic [7:0]  status_seen;
    logic        track_done;
    logic [31:0] elapsed_ticks;
  } mtep_out_t;

  typedef struct packed {
    logic step;
    logic cfg_we;
  } mtep_ctl_t;

endpackage

`default_nettype wire

// ===== sv/mtep_core.sv =====
// Track parser state and per-byte decode logic.
// Depends on mtep_pkg and the assertion macro header.
`default_nettype none
`include "midi_track_event_parser_unit_assert.svh"

module mtep_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mtep_pkg::mtep_ctl_t ctl,
  input  wire logic [31:0]       cfg_wdata,
  input  wire mtep_pkg::mtep_in_t  in_word,
  output logic                   has_result,
  output mtep_pkg::mtep_out_t    result
);
  import mtep_pkg::*;

  mtep_phase_t phase_r, phase_nxt;
  logic [7:0]  run_st_r, run_st_nxt;
  logic [7:0]  cur_st_r, cur_st_nxt;
  logic [31:0] start_r;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] elap_r, elap_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [7:0]  meta_r, meta_nxt;
  logic [23:0] tempo_r, tempo_nxt;
  logic [7:0]  first_r, first_nxt;
  logic        ended_r, ended_nxt;
  logic [1:0]  tcnt_r, tcnt_nxt;

  logic [7:0]  b;
  logic        last;
  logic [31:0] vlq_acc;
  logic        vlq_done;
  logic [32:0] sum33;
  logic        sat;
  logic [31:0] tick_add, elap_add;
  logic        consumed;
  logic [7:0]  st;
  logic        st_chan, st_sys, st_meta, st_short;
  logic        cur_short;
  logic [31:0] skip_dec;
  logic        eot;
  logic        done_f;
  logic [2:0]  kind;
  logic [3:0]  chan;
  logic [7:0]  note, vel, seen;
  logic [23:0] tempo_out;

  assign b        = in_word.data_byte;
  assign last     = in_word.chunk_end;
  assign vlq_acc  = {len_r[24:0], b[6:0]};
  assign vlq_done = ~b[7];
  assign sum33    = {1'b0, tick_r} + {1'b0, vlq_acc};
  assign sat      = sum33[32];
  assign tick_add = sat ? '1 : sum33[31:0];
  assign elap_add = sat ? ~start_r : elap_r + vlq_acc;
  assign consumed = b[7];
  assign st       = consumed ? b : run_st_r;
  assign st_chan  = st[7] && (st[7:4] != HI_SYSTEM);
  assign st_sys   = (st == ST_SYSEX) || (st == ST_SYSEX_ESC);
  assign st_meta  = (st == ST_META);
  assign st_short = (st[7:4] == HI_PROG) || (st[7:4] == HI_PRESSURE);
  assign cur_short = (cur_st_r[7:4] == HI_PROG) || (cur_st_r[7:4] == HI_PRESSURE);
  assign skip_dec = skip_r - 32'd1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (!ended_r) begin
      unique case (phase_r)
        PH_DELTA:    if (vlq_done) phase_nxt = PH_STATUS;
        PH_STATUS: begin
          if (st_chan) begin
            if (consumed)      phase_nxt = PH_DATA1;
            else if (st_short) phase_nxt = PH_DELTA;
            else               phase_nxt = PH_DATA2;
          end else if (st_sys) begin
            phase_nxt = PH_SYSLEN;
          end else if (st_meta) begin
            phase_nxt = PH_METATYPE;
          end else begin
            // a data byte with no running status also closes a one-byte delta
            phase_nxt = consumed ? PH_DELTA : PH_STATUS;
          end
        end
        PH_DATA1:    phase_nxt = cur_short ? PH_DELTA : PH_DATA2;
        PH_DATA2:    phase_nxt = PH_DELTA;
        PH_SYSLEN: begin
          if (vlq_done) phase_nxt = (vlq_acc != '0) ? PH_SKIP : PH_DELTA;
        end
        PH_SKIP:     if (skip_dec == '0) phase_nxt = PH_DELTA;
        PH_METATYPE: phase_nxt = PH_METALEN;
        PH_METALEN: begin
          if (vlq_done) begin
            if (meta_r == META_EOT)                          phase_nxt = PH_DELTA;
            else if (meta_r == META_TEMPO && vlq_acc != '0)  phase_nxt = PH_TEMPO;
            else phase_nxt = (vlq_acc != '0) ? PH_SKIP : PH_DELTA;
          end
        end
        PH_TEMPO: begin
          if (skip_dec == '0)     phase_nxt = PH_DELTA;
          else if (tcnt_r == 2'd2) phase_nxt = PH_SKIP;
        end
        default:     phase_nxt = PH_DELTA;
      endcase
    end
    if (last) phase_nxt = PH_DELTA;
  end

  // datapath and result
  always_comb begin
    run_st_nxt = run_st_r;
    cur_st_nxt = cur_st_r;
    tick_nxt   = tick_r;
    elap_nxt   = elap_r;
    len_nxt    = len_r;
    skip_nxt   = skip_r;
    meta_nxt   = meta_r;
    tempo_nxt  = tempo_r;
    first_nxt  = first_r;
    ended_nxt  = ended_r;
    tcnt_nxt   = tcnt_r;
    eot        = 1'b0;
    kind       = KIND_NONE;
    chan       = '0;
    note       = '0;
    vel        = '0;
    seen       = '0;
    tempo_out  = '0;
    if (!ended_r) begin
      case (phase_r)
        PH_DELTA: begin
          len_nxt = vlq_acc;
          if (vlq_done) begin
            tick_nxt = tick_add;
            elap_nxt = elap_add;
            len_nxt  = '0;
          end
        end
        PH_STATUS: begin
          if (st_chan) begin
            cur_st_nxt = st;
            if (consumed)       run_st_nxt = st;
            else if (!st_short) first_nxt  = b;
          end else if (st_sys) begin
            cur_st_nxt = st;
            len_nxt    = '0;
          end else if (st_meta) begin
            cur_st_nxt = st;
          end else begin
            kind    = KIND_UNKNOWN;
            seen    = st;
            len_nxt = '0;
            if (!consumed) begin
              tick_nxt = tick_add;
              elap_nxt = elap_add;
            end
          end
        end
        PH_DATA1: if (!cur_short) first_nxt = b;
        PH_DATA2: begin
          if (cur_st_r[7:4] == HI_NOTE_OFF || cur_st_r[7:4] == HI_NOTE_ON) begin
            kind = (cur_st_r[7:4] == HI_NOTE_OFF) ? KIND_NOTE_OFF : KIND_NOTE_ON;
            chan = cur_st_r[3:0];
            note = first_r;
            vel  = b;
          end
        end
        PH_SYSLEN: begin
          len_nxt = vlq_acc;
          if (vlq_done) begin
            skip_nxt = vlq_acc;
            len_nxt  = '0;
          end
        end
        PH_SKIP: skip_nxt = skip_dec;
        PH_METATYPE: begin
          meta_nxt = b;
          len_nxt  = '0;
        end
        PH_METALEN: begin
          len_nxt = vlq_acc;
          if (vlq_done) begin
            len_nxt = '0;
            if (meta_r == META_EOT) begin
              ended_nxt = 1'b1;
              eot       = 1'b1;
            end else if (meta_r == META_TEMPO && vlq_acc != '0) begin
              skip_nxt  = vlq_acc;
              tempo_nxt = '0;
              tcnt_nxt  = '0;
            end else begin
              skip_nxt = vlq_acc;
            end
          end
        end
        PH_TEMPO: begin
          tempo_nxt = {tempo_r[15:0], b};
          skip_nxt  = skip_dec;
          tcnt_nxt  = tcnt_r + 2'd1;
          if (tcnt_r == 2'd2) begin
            kind      = KIND_TEMPO;
            tempo_out = {tempo_r[15:0], b};
          end
        end
        default: len_nxt = '0;
      endcase
    end

    done_f = eot || (last && !ended_r);

    result.event_kind    = kind;
    result.event_ticks   = (kind != KIND_NONE) ? tick_nxt : '0;
    result.channel       = chan;
    result.note_number   = note;
    result.velocity      = vel;
    result.tempo_us      = tempo_out;
    result.status_seen   = seen;
    result.track_done    = done_f;
    result.elapsed_ticks = done_f ? elap_nxt : '0;
    has_result           = (kind != KIND_NONE) || done_f;

    if (last) begin
      run_st_nxt = '0;
      cur_st_nxt = '0;
      tick_nxt   = start_r;
      elap_nxt   = '0;
      len_nxt    = '0;
      skip_nxt   = '0;
      meta_nxt   = '0;
      tempo_nxt  = '0;
      first_nxt  = '0;
      ended_nxt  = 1'b0;
      tcnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_DELTA;
      run_st_r <= '0;
      cur_st_r <= '0;
      start_r  <= '0;
      tick_r   <= '0;
      elap_r   <= '0;
      len_r    <= '0;
      skip_r   <= '0;
      meta_r   <= '0;
      tempo_r  <= '0;
      first_r  <= '0;
      ended_r  <= 1'b0;
      tcnt_r   <= '0;
    end else begin
      if (ctl.step) begin
        phase_r  <= phase_nxt;
        run_st_r <= run_st_nxt;
        cur_st_r <= cur_st_nxt;
        len_r    <= len_nxt;
        skip_r   <= skip_nxt;
        meta_r   <= meta_nxt;
        tempo_r  <= tempo_nxt;
        first_r  <= first_nxt;
        ended_r  <= ended_nxt;
        tcnt_r   <= tcnt_nxt;
      end
      if (ctl.cfg_we) begin
        start_r <= cfg_wdata;
        tick_r  <= cfg_wdata;
        elap_r  <= '0;
      end else if (ctl.step) begin
        tick_r  <= tick_nxt;
        elap_r  <= elap_nxt;
      end
    end
  end

  `MTEP_ASSERT_NOW(a_ended_idle, ended_r, phase_r == PH_DELTA, "ended track left delta phase")
  `MTEP_ASSERT_NOW(a_tempo_cnt, phase_r == PH_TEMPO, tcnt_r != 2'd3, "tempo byte count overran")
  `MTEP_ASSERT_NEXT(a_restart, ctl.step && last, !ended_r && tick_r == start_r && elap_r == '0,
                    "chunk end did not restart the track")

endmodule

`default_nettype wire

// ===== sv/midi_track_event_parser_unit.sv =====
// Top level of the MIDI track event parser: input word register,
// mtep_core decode, result register. Depends on mtep_pkg, mtep_core.
//
//   channel | dir | payload     | handshake
//   in      | in  | mtep_in_t   | in_valid / in_stall
//   out     | out | mtep_out_t  | out_valid / out_stall
//   cfg     | in  | 32b start   | cfg_we, no wait
//
// One byte per cycle unless stalled; input and result are each registered.
// Rate set by the single decode pass between the input and result registers.
// Synchronous active-low reset; start_ticks resets to 0, no clearing pass.
// A held result stalls the input register, which then stalls in_valid words.
`default_nettype none
`include "midi_track_event_parser_unit_assert.svh"

module midi_track_event_parser_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mtep_pkg::mtep_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mtep_pkg::mtep_out_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_wdata
);
  import mtep_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  mtep_in_t  s1_word_r;
  logic      out_valid_r, out_valid_nxt;
  mtep_out_t out_word_r;
  logic      out_free;
  logic      advance;
  logic      accept;
  logic      has_result;
  mtep_out_t result;
  mtep_ctl_t ctl;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  assign ctl.step   = advance;
  assign ctl.cfg_we = cfg_we;

  mtep_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .cfg_wdata  (cfg_wdata),
    .in_word    (s1_word_r),
    .has_result (has_result),
    .result     (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept)       s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_free) out_valid_nxt = advance && has_result;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_word_r <= in_data;
    if (advance && has_result) out_word_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  `MTEP_ASSERT_NEXT(a_hold_word, s1_valid_r && !out_free, s1_valid_r, "held word was lost")
  `MTEP_ASSERT_NEXT(a_result_out, advance && has_result, out_valid_r, "result not registered")
  `MTEP_ASSERT_NOW(a_result_real, out_valid_r,
                   out_word_r.event_kind != KIND_NONE || out_word_r.track_done,
                   "empty result word")

endmodule

`default_nettype wire
